// ===== rtl/core/act_pkg.sv =====
// act_pkg: token kinds, scanner modes, token record and character helpers
// for the assembler tokenizer; no dependencies
`timescale 1ns / 1ps

package act_pkg;

    localparam int FIELD_W = 16;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [3:0] {
        KIND_EOS      = 4'd0,
        KIND_NEWLINE  = 4'd1,
        KIND_REGISTER = 4'd2,
        KIND_IDENT    = 4'd3,
        KIND_NUMBER   = 4'd4,
        KIND_COLON    = 4'd5,
        KIND_COMMA    = 4'd6,
        KIND_DOT      = 4'd7,
        KIND_ERROR    = 4'd8
    } tok_kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_REG     = 3'd1,
        MODE_IDENT   = 3'd2,
        MODE_ZERO    = 3'd3,
        MODE_DEC     = 3'd4,
        MODE_HEX     = 3'd5,
        MODE_COMMENT = 3'd6,
        MODE_HALT    = 3'd7
    } scan_mode_t;

    localparam logic [15:0] ERR_BAD_REGISTER = 16'd0;
    localparam logic [15:0] ERR_UNEXPECTED   = 16'd1;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0a;
    localparam logic [7:0] CH_VT        = 8'h0b;
    localparam logic [7:0] CH_FF        = 8'h0c;
    localparam logic [7:0] CH_CR        = 8'h0d;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_COMMA     = 8'h2c;
    localparam logic [7:0] CH_DOT       = 8'h2e;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_COLON     = 8'h3a;
    localparam logic [7:0] CH_SEMICOLON = 8'h3b;
    localparam logic [7:0] CH_UPPER_V   = 8'h56;
    localparam logic [7:0] CH_UPPER_X   = 8'h58;
    localparam logic [7:0] CH_UNDERLINE = 8'h5f;
    localparam logic [7:0] CH_LOWER_V   = 8'h76;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;

    typedef struct packed {
        tok_kind_t            kind;
        logic [FIELD_W-1:0]   value;
        logic [FIELD_W-1:0]   line;
        logic [FIELD_W-1:0]   column;
        logic [FIELD_W-1:0]   ident_start;
        logic [FIELD_W-1:0]   ident_length;
        logic [7:0]           bad;
        logic                 last;
    } token_t;

    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } push_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a));
    endfunction

    function automatic logic is_hex_letter(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46));
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return is_digit(b) || is_hex_letter(b);
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) || (b == CH_FF) ||
               (b == CH_CR);
    endfunction

    function automatic logic [3:0] hex_of(input logic [7:0] b);
        return is_digit(b) ? b[3:0] : 4'(b[3:0] + 4'd9);
    endfunction

endpackage

// ===== rtl/core/act_if.sv =====
// act_byte_if and act_token_if: valid/ready channels for source bytes and tokens
// depends on nothing
`timescale 1ns / 1ps

interface act_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;

    modport source (output valid, output source_byte, input ready);
    modport sink (input valid, input source_byte, output ready);
endinterface

interface act_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [15:0] token_value;
    logic [15:0] token_line;
    logic [15:0] token_column;
    logic [15:0] ident_start;
    logic [15:0] ident_length;
    logic [7:0]  offending_byte;
    logic        last_of_run;

    modport source (output valid, output token_kind, output token_value,
                    output token_line, output token_column, output ident_start,
                    output ident_length, output offending_byte, output last_of_run,
                    input ready);
    modport sink (input valid, input token_kind, input token_value,
                  input token_line, input token_column, input ident_start,
                  input ident_length, input offending_byte, input last_of_run,
                  output ready);
endinterface

// ===== rtl/core/assembler_char_tokenizer.sv =====
// assembler_char_tokenizer: top level, scanner feeding a token queue
// depends on act_pkg, act_if, act_scan, act_tok_queue
`timescale 1ns / 1ps

// usage
// src carries one source byte a beat, a zero byte marks end of source
// tok carries one token a beat with its kind, value, line, column, identifier
// offset and length, offending byte and a flag on the last token of a byte
// a byte is scanned in the cycle it is accepted; its tokens are written to a
// four-entry queue, and when the queue was empty the first shows on tok in
// the next cycle; throughput is one byte a cycle while src.ready is high;
// a byte that closes an identifier or number and is itself a token gives
// two beats, and the single tok port then sets the pace to one token a cycle
// src.ready is high while the queue has two free entries, so a stalled
// receiver holds every token and intake stops until room is made
// after an error token bytes are still taken but give no tokens until reset
// reset empties the queue and puts line and column at 1, position at 0
module assembler_char_tokenizer #(
    parameter int VALUE_WIDTH    = 16,
    parameter int POSITION_WIDTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    act_byte_if.sink     src,
    act_token_if.source  tok
);
    import act_pkg::*;

    push_t  push;
    token_t head;
    logic   fire;
    logic   not_empty;
    logic   room_for_two;

    assign src.ready = room_for_two;
    assign fire = src.valid && room_for_two;

    act_scan #(
        .VALUE_WIDTH    (VALUE_WIDTH),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .source_byte (src.source_byte),
        .push        (push)
    );

    act_tok_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_en      (fire),
        .push         (push),
        .pop          (tok.ready),
        .head         (head),
        .not_empty    (not_empty),
        .room_for_two (room_for_two)
    );

    assign tok.valid = not_empty;
    assign tok.token_kind = head.kind;
    assign tok.token_value = head.value;
    assign tok.token_line = head.line;
    assign tok.token_column = head.column;
    assign tok.ident_start = head.ident_start;
    assign tok.ident_length = head.ident_length;
    assign tok.offending_byte = head.bad;
    assign tok.last_of_run = head.last;

endmodule

// ===== rtl/core/act_scan.sv =====
// act_scan: scanner state and per-byte token decision, up to two tokens a beat
// depends on act_pkg
`timescale 1ns / 1ps

module act_scan #(
    parameter int VALUE_WIDTH    = 16,
    parameter int POSITION_WIDTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  logic [7:0]    source_byte,
    output act_pkg::push_t push
);
    import act_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int PW = POSITION_WIDTH;
    localparam int VW_EXT = (VW > FIELD_W) ? VW : FIELD_W;
    localparam int PW_EXT = (PW > FIELD_W) ? PW : FIELD_W;
    localparam logic [VW-1:0] VALUE_MAX = {VW{1'b1}};
    localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};
    localparam logic [PW-1:0] POS_ONE = PW'(1);

    scan_mode_t    mode_reg, mode_next;
    logic [VW-1:0] acc_reg, acc_next;
    logic [PW-1:0] line_reg, line_next;
    logic [PW-1:0] col_reg, col_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] sline_reg, sline_next;
    logic [PW-1:0] scol_reg, scol_next;
    logic [PW-1:0] spos_reg, spos_next;

    function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
        return (v == POS_MAX) ? POS_MAX : PW'(v + POS_ONE);
    endfunction

    function automatic logic [FIELD_W-1:0] pos16(input logic [PW-1:0] v);
        logic [PW_EXT-1:0] ext;
        ext = PW_EXT'(v);
        return ext[FIELD_W-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] val16(input logic [VW-1:0] v);
        logic [VW_EXT-1:0] ext;
        ext = VW_EXT'(v);
        return ext[FIELD_W-1:0];
    endfunction

    function automatic logic [VW-1:0] accumulate(input logic [VW-1:0] v,
                                                 input logic hex_base,
                                                 input logic [3:0] digit);
        logic [VW+4:0] wide;
        logic [VW+4:0] base;
        base = {5'b0, v};
        if (hex_base)
        begin
            wide = (base << 4) + (VW+5)'(digit);
        end
        else
        begin
            wide = (base << 3) + (base << 1) + (VW+5)'(digit);
        end
        return (|wide[VW+4:VW]) ? VALUE_MAX : wide[VW-1:0];
    endfunction

    // start-of-token decision, shared by idle, a token's end and NUL in a comment
    logic          st_emit;
    token_t        st_tok;
    scan_mode_t    st_mode;
    logic          st_consume;
    logic          st_mark;
    logic          st_acc_load;
    logic [VW-1:0] st_acc_val;
    token_t        blank_tok;

    always_comb
    begin
        blank_tok = '0;
        blank_tok.kind = KIND_EOS;
        blank_tok.line = pos16(line_reg);
        blank_tok.column = pos16(col_reg);

        st_emit = 1'b0;
        st_tok = blank_tok;
        st_mode = MODE_IDLE;
        st_consume = 1'b0;
        st_mark = 1'b0;
        st_acc_load = 1'b0;
        st_acc_val = '0;

        if (is_blank(source_byte))
        begin
            st_consume = 1'b1;
        end
        else if (source_byte == CH_SEMICOLON)
        begin
            st_consume = 1'b1;
            st_mode = MODE_COMMENT;
        end
        else if (source_byte == CH_NUL)
        begin
            st_emit = 1'b1;
            st_tok.kind = KIND_EOS;
        end
        else if (source_byte == CH_NEWLINE)
        begin
            st_emit = 1'b1;
            st_tok.kind = KIND_NEWLINE;
            st_consume = 1'b1;
        end
        else if ((source_byte == CH_LOWER_V) || (source_byte == CH_UPPER_V))
        begin
            st_mark = 1'b1;
            st_consume = 1'b1;
            st_mode = MODE_REG;
        end
        else if (is_alpha(source_byte) || (source_byte == CH_UNDERLINE))
        begin
            st_mark = 1'b1;
            st_consume = 1'b1;
            st_mode = MODE_IDENT;
        end
        else if (source_byte == CH_ZERO)
        begin
            st_mark = 1'b1;
            st_acc_load = 1'b1;
            st_consume = 1'b1;
            st_mode = MODE_ZERO;
        end
        else if (is_digit(source_byte))
        begin
            st_mark = 1'b1;
            st_acc_load = 1'b1;
            st_acc_val = VW'(source_byte[3:0]);
            st_consume = 1'b1;
            st_mode = MODE_DEC;
        end
        else if ((source_byte == CH_COLON) || (source_byte == CH_COMMA) ||
                 (source_byte == CH_DOT))
        begin
            st_emit = 1'b1;
            st_consume = 1'b1;
            st_tok.kind = (source_byte == CH_COLON) ? KIND_COLON :
                          ((source_byte == CH_COMMA) ? KIND_COMMA : KIND_DOT);
        end
        else
        begin
            st_emit = 1'b1;
            st_tok.kind = KIND_ERROR;
            st_tok.value = ERR_UNEXPECTED;
            st_tok.bad = source_byte;
            st_mode = MODE_HALT;
        end
    end

    logic   emit_a;
    token_t tok_a;
    logic   use_start;
    logic   consume;
    logic   mark;
    token_t number_tok;

    always_comb
    begin
        number_tok = blank_tok;
        number_tok.kind = KIND_NUMBER;
        number_tok.value = val16(acc_reg);
        number_tok.line = pos16(sline_reg);
        number_tok.column = pos16(scol_reg);

        mode_next = mode_reg;
        acc_next = acc_reg;
        consume = 1'b0;
        mark = 1'b0;
        emit_a = 1'b0;
        tok_a = blank_tok;
        use_start = 1'b0;

        case (mode_reg)
            MODE_HALT:
            begin
                mode_next = MODE_HALT;
            end
            MODE_REG:
            begin
                emit_a = 1'b1;
                tok_a.line = pos16(sline_reg);
                tok_a.column = pos16(scol_reg);
                if (is_hex(source_byte))
                begin
                    tok_a.kind = KIND_REGISTER;
                    tok_a.value = FIELD_W'(hex_of(source_byte));
                    consume = 1'b1;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    tok_a.kind = KIND_ERROR;
                    tok_a.value = ERR_BAD_REGISTER;
                    tok_a.bad = source_byte;
                    mode_next = MODE_HALT;
                end
            end
            MODE_IDENT:
            begin
                if (is_alpha(source_byte) || is_digit(source_byte) ||
                    (source_byte == CH_UNDERLINE))
                begin
                    consume = 1'b1;
                end
                else
                begin
                    emit_a = 1'b1;
                    tok_a.kind = KIND_IDENT;
                    tok_a.line = pos16(sline_reg);
                    tok_a.column = pos16(scol_reg);
                    tok_a.ident_start = pos16(spos_reg);
                    tok_a.ident_length = pos16(PW'(pos_reg - spos_reg));
                    use_start = 1'b1;
                end
            end
            MODE_ZERO:
            begin
                if ((source_byte == CH_LOWER_X) || (source_byte == CH_UPPER_X))
                begin
                    consume = 1'b1;
                    mode_next = MODE_HEX;
                end
                else if (is_digit(source_byte))
                begin
                    acc_next = accumulate(acc_reg, 1'b0, source_byte[3:0]);
                    consume = 1'b1;
                    mode_next = MODE_DEC;
                end
                else
                begin
                    emit_a = 1'b1;
                    tok_a = number_tok;
                    use_start = 1'b1;
                end
            end
            MODE_DEC:
            begin
                if (is_digit(source_byte))
                begin
                    acc_next = accumulate(acc_reg, 1'b0, source_byte[3:0]);
                    consume = 1'b1;
                end
                else
                begin
                    emit_a = 1'b1;
                    tok_a = number_tok;
                    use_start = 1'b1;
                end
            end
            MODE_HEX:
            begin
                if (is_hex(source_byte))
                begin
                    acc_next = accumulate(acc_reg, 1'b1, hex_of(source_byte));
                    consume = 1'b1;
                end
                else
                begin
                    emit_a = 1'b1;
                    tok_a = number_tok;
                    use_start = 1'b1;
                end
            end
            MODE_COMMENT:
            begin
                if (source_byte == CH_NUL)
                begin
                    use_start = 1'b1;
                end
                else
                begin
                    consume = 1'b1;
                    if (source_byte == CH_NEWLINE)
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
            end
            default:
            begin
                use_start = 1'b1;
            end
        endcase

        if (use_start)
        begin
            mode_next = st_mode;
            consume = st_consume;
            mark = st_mark;
            if (st_acc_load)
            begin
                acc_next = st_acc_val;
            end
        end

        sline_next = mark ? line_reg : sline_reg;
        scol_next = mark ? col_reg : scol_reg;
        spos_next = mark ? pos_reg : spos_reg;

        pos_next = consume ? sat_inc(pos_reg) : pos_reg;
        line_next = line_reg;
        col_next = col_reg;
        if (consume)
        begin
            if (source_byte == CH_NEWLINE)
            begin
                line_next = sat_inc(line_reg);
                col_next = POS_ONE;
            end
            else
            begin
                col_next = sat_inc(col_reg);
            end
        end
    end

    // pack the tokens of this beat, last flag on the final one
    always_comb
    begin
        push.first = emit_a ? tok_a : st_tok;
        push.second = st_tok;
        push.first.last = 1'b0;
        push.second.last = 1'b1;
        if (emit_a && use_start && st_emit)
        begin
            push.count = 2'd2;
        end
        else if (emit_a || (use_start && st_emit))
        begin
            push.count = 2'd1;
            push.first.last = 1'b1;
        end
        else
        begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            acc_reg <= '0;
            line_reg <= POS_ONE;
            col_reg <= POS_ONE;
            pos_reg <= '0;
            sline_reg <= POS_ONE;
            scol_reg <= POS_ONE;
            spos_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            acc_reg <= acc_next;
            line_reg <= line_next;
            col_reg <= col_next;
            pos_reg <= pos_next;
            sline_reg <= sline_next;
            scol_reg <= scol_next;
            spos_reg <= spos_next;
        end
    end

endmodule

// ===== rtl/core/act_tok_queue.sv =====
// act_tok_queue: four-entry token queue, takes up to two tokens a beat, gives one
// depends on act_pkg
`timescale 1ns / 1ps

module act_tok_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_en,
    input  act_pkg::push_t  push,
    input  logic            pop,
    output act_pkg::token_t head,
    output logic            not_empty,
    output logic            room_for_two
);
    import act_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    token_t          entry_reg [QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [1:0]      n_push;
    logic            do_pop;
    logic [AW-1:0]   wr_ptr_plus1;

    assign n_push = push_en ? push.count : 2'd0;
    assign do_pop = pop && (count_reg != '0);
    assign wr_ptr_plus1 = AW'(wr_ptr_reg + AW'(1));

    always_comb
    begin
        wr_ptr_next = AW'(wr_ptr_reg + AW'(n_push));
        rd_ptr_next = do_pop ? AW'(rd_ptr_reg + AW'(1)) : rd_ptr_reg;
        count_next = CW'(count_reg + CW'(n_push) - CW'(do_pop));
    end

    assign head = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign room_for_two = (count_reg <= CW'(QUEUE_DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (n_push == 2'd2)
        begin
            entry_reg[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/act_checker.sv =====
// act_checker: port-level checks on the tokenizer, bound to the top level
// depends on act_pkg and assembler_char_tokenizer
`timescale 1ns / 1ps

module act_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        tok_valid,
    input logic        tok_ready,
    input logic [3:0]  tok_kind,
    input logic [15:0] tok_line,
    input logic [15:0] tok_start,
    input logic [15:0] tok_length,
    input logic        tok_last
);
    import act_pkg::*;

    // nothing follows an error token
    assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && tok_ready && (tok_kind == KIND_ERROR)) |=> !tok_valid)
    else $error("token after error");

    // an error token always closes the tokens of its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && (tok_kind == KIND_ERROR)) |-> tok_last)
    else $error("error token not last of run");

    // identifier fields stay zero on other kinds
    assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && (tok_kind != KIND_IDENT)) |-> ((tok_start == 16'd0) &&
                                                      (tok_length == 16'd0)))
    else $error("identifier fields set on non-identifier");

    // lines count from one
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> (tok_line != 16'd0))
    else $error("line zero");

    // a stalled beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && !tok_ready) |=> (tok_valid && $stable(tok_kind) &&
                                       $stable(tok_line)))
    else $error("stalled token changed");

endmodule

bind assembler_char_tokenizer act_checker u_act_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok_valid  (tok.valid),
    .tok_ready  (tok.ready),
    .tok_kind   (tok.token_kind),
    .tok_line   (tok.token_line),
    .tok_start  (tok.ident_start),
    .tok_length (tok.ident_length),
    .tok_last   (tok.last_of_run)
);
